FILE: src/positional_list_table_top_defines.svh
// Assertion macros used by the checker file plt_checker.sv of this block.
`ifndef POSITIONAL_LIST_TABLE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PLT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define PLT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/plt_pkg.sv
package plt_pkg;

  localparam int CNT_W = 5;
  localparam int POS_W = 5;
  localparam int VAL_W = 32;
  localparam int CMD_W = 3;
  localparam int ST_W  = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_READ   = 3'd3,
    CMD_WRITE  = 3'd4,
    CMD_SEARCH = 3'd5
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_WALK = 2'd1,
    S_DONE = 2'd2
  } state_t;

  typedef struct packed {
    logic load;
    logic walk;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic need_walk;
    logic walk_done;
  } dp_stat_t;

endpackage

FILE: src/plt_if.sv
interface plt_in_if import plt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, cmd, position, value, input ready);
  modport sink (input valid, cmd, position, value, output ready);
endinterface

interface plt_out_if import plt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic signed [VAL_W-1:0] read_value;
  logic                    found;
  logic [POS_W-1:0]        found_position;
  logic [CNT_W-1:0]        count;

  modport source (output valid, status, read_value, found, found_position, count,
                  input ready);
  modport sink (input valid, status, read_value, found, found_position, count,
                output ready);
endinterface

FILE: src/positional_list_table_top.sv
// Flow: an item is accepted in IDLE and registered; insert, remove, read and search with entries
// to walk then pass through WALK, and every item ends in DONE, where its result is registered
// once the output is free. A new item is taken only after the last result is committed; the
// walk over the entry memory reads one entry per cycle.
// Reset (rst_n low, synchronous): count 0, capacity 16; entry contents stay undefined.
module positional_list_table_top import plt_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  plt_in_if.sink           in_ch,
  plt_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  plt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  plt_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (dp_cmd),
    .stat               (dp_stat),
    .in_cmd             (in_ch.cmd),
    .in_position        (in_ch.position),
    .in_value           (in_ch.value),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_status         (out_ch.status),
    .out_read_value     (out_ch.read_value),
    .out_found          (out_ch.found),
    .out_found_position (out_ch.found_position),
    .out_count          (out_ch.count)
  );

endmodule

FILE: src/plt_ctrl.sv
module plt_ctrl import plt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.need_walk ? S_WALK : S_DONE;
        end
      end
      S_WALK: begin
        if (stat.walk_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.walk   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_WALK: cmd.walk = 1'b1;
      S_DONE: cmd.commit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: src/plt_dp.sv
module plt_dp import plt_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  input  logic [CMD_W-1:0]        in_cmd,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    cfg_we,
  input  logic [CNT_W-1:0]        cfg_wdata,
  output logic [ST_W-1:0]         out_status,
  output logic signed [VAL_W-1:0] out_read_value,
  output logic                    out_found,
  output logic [POS_W-1:0]        out_found_position,
  output logic [CNT_W-1:0]        out_count
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WW = (IW > CNT_W) ? IW : CNT_W;
  localparam logic [CNT_W-1:0] DEPTH_SAT = (DEPTH > 31) ? 5'd31 : CNT_W'(DEPTH);

  function automatic logic [IW-1:0] to_idx(input logic [CNT_W-1:0] x);
    logic [WW-1:0] w;
    w = WW'(x);
    return w[IW-1:0];
  endfunction

  logic [VAL_W-1:0] mem [DEPTH];

  logic [CNT_W-1:0] cap_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  cmd_t             cmd_r;
  logic [POS_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;
  status_t          status_r, status_nxt;
  logic [CNT_W-1:0] rem_r, rem_init;
  logic [IW-1:0]    ptr_r, ptr_init;
  logic             pv_r;
  logic [IW-1:0]    paddr_r;
  logic [VAL_W-1:0] rdata_r;
  logic [VAL_W-1:0] rd_val_r;
  logic             found_r;
  logic [POS_W-1:0] fpos_r;

  logic [CNT_W-1:0] lim;
  logic             full, pos_in, ins_in, issue, ok;
  cmd_t             in_code;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  logic [VAL_W-1:0] wr_data;
  logic [WW-1:0]    paddr_w;

  assign in_code = cmd_t'(in_cmd);
  assign lim     = (cap_r < DEPTH_SAT) ? cap_r : DEPTH_SAT;
  assign full    = count_r >= lim;
  assign pos_in  = (in_position != '0) && (in_position <= count_r);
  assign ins_in  = (in_position != '0) &&
                   ({1'b0, in_position} <= ({1'b0, count_r} + 6'd1));

  always_comb begin
    status_nxt = ST_OK;
    rem_init   = '0;
    ptr_init   = '0;
    case (in_code)
      CMD_APPEND: begin
        if (full) begin
          status_nxt = ST_FULL;
        end
      end
      CMD_INSERT: begin
        if (!ins_in) begin
          status_nxt = ST_RANGE;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          rem_init = count_r + 5'd1 - in_position;
          ptr_init = to_idx(count_r - 5'd1);
        end
      end
      CMD_REMOVE: begin
        if (!pos_in) begin
          status_nxt = ST_RANGE;
        end else begin
          rem_init = count_r - in_position;
          ptr_init = to_idx(in_position);
        end
      end
      CMD_READ: begin
        if (!pos_in) begin
          status_nxt = ST_RANGE;
        end else begin
          rem_init = 5'd1;
          ptr_init = to_idx(in_position - 5'd1);
        end
      end
      CMD_WRITE: begin
        if (!pos_in) begin
          status_nxt = ST_RANGE;
        end
      end
      CMD_SEARCH: begin
        rem_init = count_r;
      end
      default: ;
    endcase
  end

  assign stat.need_walk = rem_init != '0;
  assign stat.walk_done = ((rem_r == '0) || found_r) && !pv_r;
  assign issue          = cmd.walk && (rem_r != '0) && !found_r;
  assign ok             = status_r == ST_OK;
  assign paddr_w        = WW'(paddr_r) + WW'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= in_code;
      pos_r    <= in_position;
      val_r    <= in_value;
      status_r <= status_nxt;
      rem_r    <= rem_init;
      ptr_r    <= ptr_init;
      found_r  <= 1'b0;
      fpos_r   <= '0;
      rd_val_r <= '0;
    end else begin
      if (issue) begin
        rem_r   <= rem_r - 5'd1;
        ptr_r   <= (cmd_r == CMD_INSERT) ? ptr_r - IW'(1) : ptr_r + IW'(1);
        paddr_r <= ptr_r;
      end
      if (pv_r) begin
        case (cmd_r)
          CMD_SEARCH: begin
            if (!found_r && (rdata_r == val_r)) begin
              found_r <= 1'b1;
              fpos_r  <= paddr_w[POS_W-1:0];
            end
          end
          CMD_READ: rd_val_r <= rdata_r;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rdata_r;
    if (pv_r && (cmd_r == CMD_INSERT)) begin
      wr_en   = 1'b1;
      wr_addr = paddr_r + IW'(1);
    end else if (pv_r && (cmd_r == CMD_REMOVE)) begin
      wr_en   = 1'b1;
      wr_addr = paddr_r - IW'(1);
    end else if (cmd.commit && ok) begin
      wr_data = val_r;
      case (cmd_r)
        CMD_APPEND: begin
          wr_en   = 1'b1;
          wr_addr = to_idx(count_r);
        end
        CMD_INSERT, CMD_WRITE: begin
          wr_en   = 1'b1;
          wr_addr = to_idx(pos_r - 5'd1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rdata_r <= mem[ptr_r];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ok) begin
      case (cmd_r)
        CMD_APPEND, CMD_INSERT: count_nxt = count_r + 5'd1;
        CMD_REMOVE:             count_nxt = count_r - 5'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      count_r <= '0;
      pv_r    <= 1'b0;
    end else begin
      pv_r <= issue;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (cmd.commit) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status         <= status_r;
      out_read_value     <= rd_val_r;
      out_found          <= found_r;
      out_found_position <= fpos_r;
      out_count          <= count_nxt;
    end
  end

endmodule

FILE: src/plt_checker.sv
`include "positional_list_table_top_defines.svh"

module plt_checker import plt_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ST_W-1:0]  out_status,
  input logic [VAL_W-1:0] out_read_value,
  input logic             out_found,
  input logic [POS_W-1:0] out_found_position
);

  logic err_result;
  logic err_clean;
  logic found_ok;

  assign err_result = out_valid && (out_status != ST_OK);
  assign err_clean  = (out_read_value == '0) && !out_found;
  assign found_ok   = out_found == (out_found_position != '0);

  `PLT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `PLT_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "item taken while busy")
  `PLT_ASSERT_IMP(a_found_pos, out_valid, found_ok, "found mismatch")
  `PLT_ASSERT_IMP(a_err_zero, err_result, err_clean, "error result not clean")

endmodule

bind positional_list_table_top plt_checker u_plt_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_status         (out_ch.status),
  .out_read_value     (out_ch.read_value),
  .out_found          (out_ch.found),
  .out_found_position (out_ch.found_position)
);

FILE: test/plt_list_checker.sv
`timescale 1ns / 1ps

module plt_list_checker import plt_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  plt_in_if                in_ch,
  plt_out_if               out_ch,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  output int               error_count,
  output int               pending_count,
  output int               list_size
);

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] read_value;
    logic                    found;
    logic [POS_W-1:0]        found_position;
    logic [CNT_W-1:0]        count;
  } list_result_t;

  logic signed [VAL_W-1:0] list_mem [DEPTH];
  int unsigned             list_len;
  int unsigned             capacity;
  list_result_t            expected_results [$];

  function automatic list_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                 input int unsigned pos,
                                                 input logic signed [VAL_W-1:0] val);
    list_result_t res;
    int unsigned  limit;
    int unsigned  i;
    res = '0;
    limit = (capacity < DEPTH) ? capacity : DEPTH;
    case (cmd)
      CMD_APPEND: begin
        if (list_len >= limit) begin
          res.status = ST_FULL;
        end else begin
          list_mem[list_len] = val;
          list_len++;
        end
      end
      CMD_INSERT: begin
        // The position is checked before fullness.
        if (pos < 1 || pos > list_len + 1) begin
          res.status = ST_RANGE;
        end else if (list_len >= limit) begin
          res.status = ST_FULL;
        end else begin
          for (i = list_len; i >= pos; i--) begin
            list_mem[i] = list_mem[i-1];
          end
          list_mem[pos-1] = val;
          list_len++;
        end
      end
      CMD_REMOVE: begin
        if (pos < 1 || pos > list_len) begin
          res.status = ST_RANGE;
        end else begin
          for (i = pos - 1; i + 1 < list_len; i++) begin
            list_mem[i] = list_mem[i+1];
          end
          list_len--;
        end
      end
      CMD_READ: begin
        if (pos < 1 || pos > list_len) begin
          res.status = ST_RANGE;
        end else begin
          res.read_value = list_mem[pos-1];
        end
      end
      CMD_WRITE: begin
        if (pos < 1 || pos > list_len) begin
          res.status = ST_RANGE;
        end else begin
          list_mem[pos-1] = val;
        end
      end
      CMD_SEARCH: begin
        for (i = 0; i < list_len && !res.found; i++) begin
          if (list_mem[i] == val) begin
            res.found = 1'b1;
            res.found_position = POS_W'(i + 1);
          end
        end
      end
      default: begin
      end
    endcase
    res.count = CNT_W'(list_len);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    list_result_t want;
    if (!rst_n) begin
      list_len = 0;
      capacity = 32'(CAP_RESET);
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        capacity = 32'(cfg_wdata);
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(apply_command(in_ch.cmd, 32'(in_ch.position),
                                                 in_ch.value));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("Result item arrived with no command outstanding.");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", VAL_W'(want.status), VAL_W'(out_ch.status));
          check_field("read_value", want.read_value, out_ch.read_value);
          check_field("found", VAL_W'(want.found), VAL_W'(out_ch.found));
          check_field("found_position", VAL_W'(want.found_position),
                      VAL_W'(out_ch.found_position));
          check_field("count", VAL_W'(want.count), VAL_W'(out_ch.count));
        end
      end
    end
    pending_count = expected_results.size();
    list_size = list_len;
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import plt_pkg::*;

  localparam int DEPTH = 16;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;
  int               error_count;
  int               pending_count;
  int               list_size;
  int               send_idle_pct;
  int               recv_stall_pct;
  int               hold_requests;
  int               value_pool [8];

  plt_in_if  in_ch ();
  plt_out_if out_ch ();

  positional_list_table_top #(.DEPTH(DEPTH)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  plt_list_checker #(.DEPTH(DEPTH)) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .error_count   (error_count),
    .pending_count (pending_count),
    .list_size     (list_size)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(64'd10_000_000);
    $display("TEST FAILED");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  initial begin : result_sink
    int hold_served;
    int hold_left;
    hold_served = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic int pick_value();
    case ($urandom_range(9))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 0;
      3: return -1;
      4, 5: return value_pool[$urandom_range(7)];
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                           input logic signed [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.position <= pos;
    in_ch.value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] cap);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_command();
    int                      pick;
    int                      span;
    logic [CMD_W-1:0]        cmd;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    pick = $urandom_range(99);
    if (pick < 25) cmd = CMD_APPEND;
    else if (pick < 45) cmd = CMD_INSERT;
    else if (pick < 65) cmd = CMD_REMOVE;
    else if (pick < 77) cmd = CMD_READ;
    else if (pick < 87) cmd = CMD_WRITE;
    else if (pick < 97) cmd = CMD_SEARCH;
    else if (pick < 99) cmd = CMD_SPARE_A;
    else cmd = CMD_SPARE_B;
    span = (cmd == CMD_INSERT) ? list_size + 1 : list_size;
    if (span > 0 && $urandom_range(99) < 85) begin
      pos = POS_W'($urandom_range(span, 1));
    end else begin
      pos = POS_W'($urandom_range(31));
    end
    if (cmd == CMD_SEARCH && $urandom_range(99) < 70) begin
      val = value_pool[$urandom_range(7)];
    end else begin
      val = pick_value();
    end
    if (cmd == CMD_APPEND || cmd == CMD_INSERT || cmd == CMD_WRITE) begin
      value_pool[$urandom_range(7)] = val;
    end
    send_item(cmd, pos, val);
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] cap, input int send_pct,
                           input int recv_pct, input int items, input bit hold_off);
    write_capacity(cap);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    if (hold_off) begin
      hold_requests++;
    end
    repeat (items) send_random_command();
    wait_idle();
  endtask

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests = 0;
    foreach (value_pool[i]) value_pool[i] = $urandom;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= CMD_APPEND;
    in_ch.position <= '0;
    in_ch.value <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list: every positional command out of range; then fill, probe bounds.
    send_item(CMD_READ, 5'd1, 0);
    send_item(CMD_REMOVE, 5'd1, 0);
    send_item(CMD_INSERT, 5'd0, 1);
    send_item(CMD_INSERT, 5'd2, 1);
    send_item(CMD_SEARCH, 5'd0, 0);
    send_item(CMD_APPEND, 5'd0, 32'sh7FFF_FFFF);
    send_item(CMD_APPEND, 5'd0, 32'sh8000_0000);
    send_item(CMD_INSERT, 5'd1, -1);
    send_item(CMD_INSERT, 5'd4, 0);
    send_item(CMD_INSERT, 5'd2, 5);
    send_item(CMD_READ, 5'd1, 0);
    send_item(CMD_READ, 5'd6, 0);
    send_item(CMD_READ, 5'd31, 0);
    send_item(CMD_READ, 5'd16, 0);
    send_item(CMD_WRITE, 5'd3, 32'sh8000_0000);
    send_item(CMD_WRITE, 5'd0, 9);
    send_item(CMD_SEARCH, 5'd0, 32'sh8000_0000);
    send_item(CMD_SEARCH, 5'd0, 12345);
    send_item(CMD_REMOVE, 5'd5, 0);
    send_item(CMD_REMOVE, 5'd1, 0);
    send_item(CMD_SPARE_A, 5'd3, 77);
    send_item(CMD_SPARE_B, 5'd31, -1);
    wait_idle();

    // Capacity lowered below the count, then zero, then above the built depth.
    write_capacity(5'd2);
    send_item(CMD_APPEND, 5'd0, 1);
    send_item(CMD_INSERT, 5'd1, 2);
    send_item(CMD_INSERT, 5'd9, 3);
    send_item(CMD_REMOVE, 5'd1, 0);
    wait_idle();
    write_capacity(5'd0);
    send_item(CMD_APPEND, 5'd0, 4);
    wait_idle();
    write_capacity(5'd31);
    send_item(CMD_APPEND, 5'd0, 7);
    wait_idle();

    run_phase(5'd16, 0, 0, 160, 1'b0);
    run_phase(5'd1, 81, 0, 80, 1'b0);
    run_phase(5'd8, 0, 81, 160, 1'b0);
    run_phase(5'd16, 15, 15, 160, 1'b0);
    run_phase(5'd5, 0, 0, 60, 1'b1);
    run_phase(5'd0, 15, 15, 30, 1'b0);

    repeat (DEPTH + 5) @(posedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: positional_list_table_top.f
+incdir+src
src/plt_pkg.sv
src/plt_if.sv
src/plt_ctrl.sv
src/plt_dp.sv
src/positional_list_table_top.sv
src/plt_checker.sv
test/plt_list_checker.sv
test/testbench.sv
